FILE: hw/rtl/efd_pkg.sv
// Package for the escaped frame deframer: phase and event codes,
// special byte values and the default payload limit. No dependencies.
package efd_pkg;

  localparam int unsigned MaxPayloadDefault = 256;

  localparam logic [7:0] ByteOpen  = 8'h7E;
  localparam logic [7:0] ByteClose = 8'h7F;
  localparam logic [7:0] ByteEsc   = 8'h7D;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] SumGood   = 8'hFF;

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_OPENED   = 2'd1,
    PH_IN_FRAME = 2'd2,
    PH_ESCAPED  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_GOOD     = 3'd2,
    EV_BAD      = 3'd3,
    EV_ABORT    = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_t;

endpackage

FILE: hw/rtl/escaped_frame_deframer_sum_check.sv
// Top level of the byte-stuffed frame deframer with an 8-bit sum check.
// Depends on efd_pkg for phase/event codes and special byte values.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one raw serial byte
//   per item. Output channel (out_valid/out_ready/out_*) returns exactly one
//   result item per input item, in order: event code plus payload byte and
//   index (payload event) or frame length and sum (good/bad close).
//   Frames open with 0x7E and close with 0x7F; 0x7D escapes the next byte,
//   which is XORed with 0x20. A 0x7E inside a frame with payload aborts it;
//   a payload byte beyond MAX_PAYLOAD flags overflow and drops the frame.
//
// Pipeline: an accepted item enters the input register; the result register
// loads from it once the result register is empty or being taken.
// Throughput: 1 item per cycle while out_ready is high; the frame state
// update is a single pass of compare, add and select between the input and
// result registers.
// Reset (rst_n low, synchronous): both stages empty, block hunting for an
// opener with count and sum cleared.
// Stall: when out_ready is low the result register holds; the input register
// still takes one more item, then in_ready drops until the result is taken.
module escaped_frame_deframer_sum_check
  import efd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_byte_index,
  output logic [8:0] out_frame_length,
  output logic [7:0] out_frame_sum
);

  // Count must reach MAX_PAYLOAD itself.
  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PAYLOAD);

  // Input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Frame state
  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      sum_r, sum_nxt;

  // Result register
  logic       out_valid_r;
  event_t     ev_r, ev_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [8:0] len_r, len_nxt;
  logic [7:0] fsum_r, fsum_nxt;

  logic            advance;
  logic [7:0]      take_val;
  logic            take_en;
  logic [CntW+8:0] cnt_wide;

  // Result register frees when empty or being taken; stage 1 moves then.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign cnt_wide = {9'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Decode one byte against the frame state.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    ev_nxt    = EV_NONE;
    pb_nxt    = 8'd0;
    idx_nxt   = 8'd0;
    len_nxt   = 9'd0;
    fsum_nxt  = 8'd0;
    take_en   = 1'b0;
    take_val  = s1_byte_r;

    case (phase_r)
      PH_HUNT: begin
        if (s1_byte_r == ByteOpen) begin
          phase_nxt = PH_OPENED;
          cnt_nxt   = '0;
          sum_nxt   = 8'd0;
        end
      end
      PH_OPENED: begin
        if (s1_byte_r == ByteEsc) begin
          phase_nxt = PH_ESCAPED;
        end else if (s1_byte_r == ByteOpen) begin
          // repeated opener: ignore
        end else if (s1_byte_r == ByteClose) begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = 8'd0;
        end else begin
          take_en = 1'b1;
        end
      end
      PH_IN_FRAME: begin
        if (s1_byte_r == ByteEsc) begin
          phase_nxt = PH_ESCAPED;
        end else if (s1_byte_r == ByteOpen) begin
          ev_nxt    = EV_ABORT;
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = 8'd0;
        end else if (s1_byte_r == ByteClose) begin
          ev_nxt    = (sum_r == SumGood) ? EV_GOOD : EV_BAD;
          len_nxt   = cnt_wide[8:0];
          fsum_nxt  = sum_r;
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = 8'd0;
        end else begin
          take_en = 1'b1;
        end
      end
      PH_ESCAPED: begin
        take_en  = 1'b1;
        take_val = s1_byte_r ^ EscXor;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    // Take a payload byte, or drop the frame when already full.
    if (take_en) begin
      if (cnt_r >= CntMax) begin
        ev_nxt    = EV_OVERFLOW;
        phase_nxt = PH_HUNT;
        cnt_nxt   = '0;
        sum_nxt   = 8'd0;
      end else begin
        ev_nxt    = EV_PAYLOAD;
        pb_nxt    = take_val;
        idx_nxt   = cnt_wide[7:0];
        cnt_nxt   = cnt_r + CntW'(1);
        sum_nxt   = sum_r + take_val;
        phase_nxt = PH_IN_FRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      cnt_r       <= '0;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      ev_r   <= ev_nxt;
      pb_r   <= pb_nxt;
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      fsum_r <= fsum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_payload_byte = pb_r;
  assign out_byte_index   = idx_r;
  assign out_frame_length = len_r;
  assign out_frame_sum    = fsum_r;

  // A good close always carries the expected sum, a bad one never does.
  a_good_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_GOOD) |-> (fsum_r == SumGood))
    else $error("good frame without matching sum");

  a_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_BAD) |-> (fsum_r != SumGood))
    else $error("bad frame with matching sum");

  // Hunting always holds a cleared count and sum.
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (cnt_r == '0 && sum_r == 8'd0))
    else $error("hunt phase with stale frame state");

  // Count never grows past the payload limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntMax)
    else $error("byte count past payload limit");

  // A held result keeps its event while the receiver stalls.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(ev_r) && $stable(phase_r)))
    else $error("result or state changed during stall");

endmodule
